// ----- rtl/kvp_pkg.sv -----
// Package for the key-value record beat parser.
// Holds beat geometry, result codes and the structs shared by lanes, merge and buffer.
// No dependencies.
package kvp_pkg;

    localparam int BEAT_BYTES    = 32;
    localparam int LANE_BYTES    = 8;
    localparam int LANES         = BEAT_BYTES / LANE_BYTES;
    localparam int BEAT_W        = BEAT_BYTES * 8;
    localparam int HDR_SPAN      = BEAT_BYTES - 2;
    localparam int MAX_KEY_BYTES = 30;
    localparam int KEY_CAP       = (MAX_KEY_BYTES < HDR_SPAN) ? MAX_KEY_BYTES : HDR_SPAN;
    localparam int RES_SLOTS     = 3;

    typedef logic [7:0]        t_byte;
    typedef logic [BEAT_W-1:0] t_beat;
    typedef logic [63:0]       t_word;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_ARRAY  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        t_beat       words;
        logic [4:0]  key_length;
        logic [15:0] count;
        logic [7:0]  meta;
        logic [63:0] base;
        logic [31:0] delta;
        logic [1:0]  flags;
        logic        last;
    } t_result;

    typedef struct packed {
        t_result [RES_SLOTS-1:0] slot;
        logic [1:0]              cnt;
    } t_bundle;

    // shift controls handed to every lane
    typedef struct packed {
        logic [4:0] eff;        // key bytes kept on a first word
        logic [4:0] off_first;  // value bytes left in a first word
        logic [4:0] off_cont;   // carried bytes ahead of a later word
    } t_lane_ctl;

    typedef struct packed {
        t_word key;
        t_word carry_first;
        t_word value;
        t_word carry_next;
    } t_lane_out;

    // byte idx of a word, zero beyond the end
    function automatic t_byte byte_sel(t_beat beat, logic [5:0] idx);
        t_byte b;
        b = '0;
        if (!idx[5]) begin
            b = beat[(BEAT_BYTES - 1 - int'(idx[4:0])) * 8 +: 8];
        end
        return b;
    endfunction

endpackage

// ----- rtl/kvp_beat_if.sv -----
// Input channel of the record beat parser: valid/ready plus the beat and its descriptor.
// No dependencies.
interface kvp_beat_if;
    logic        valid;
    logic        ready;
    logic [63:0] lane0;
    logic [63:0] lane1;
    logic [63:0] lane2;
    logic [63:0] lane3;
    logic [15:0] record_length;
    logic [7:0]  meta_tag;
    logic        array_first_in;
    logic        array_in;
    logic [63:0] slab_address;
    logic [31:0] delta_in;

    modport source (
        output valid, lane0, lane1, lane2, lane3, record_length, meta_tag,
               array_first_in, array_in, slab_address, delta_in,
        input  ready
    );
    modport sink (
        input  valid, lane0, lane1, lane2, lane3, record_length, meta_tag,
               array_first_in, array_in, slab_address, delta_in,
        output ready
    );
endinterface

// ----- rtl/kvp_result_if.sv -----
// Output channel of the record beat parser: valid/ready plus one result.
// No dependencies.
interface kvp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic [4:0]  key_length;
    logic [15:0] count_out;
    logic [7:0]  meta_out;
    logic [63:0] base_out;
    logic [31:0] delta_out;
    logic [1:0]  flags_out;
    logic        last;

    modport source (
        output valid, kind, word0, word1, word2, word3, key_length, count_out,
               meta_out, base_out, delta_out, flags_out, last,
        input  ready
    );
    modport sink (
        input  valid, kind, word0, word1, word2, word3, key_length, count_out,
               meta_out, base_out, delta_out, flags_out, last,
        output ready
    );
endinterface

// ----- rtl/kvp_lane.sv -----
// One 8-byte lane of the byte realigner: builds its slice of the key, first carry,
// value word and next carry. Depends on kvp_pkg.
module kvp_lane
    import kvp_pkg::*;
#(
    parameter int LANE = 0
) (
    input  t_beat     i_beat,
    input  t_word     i_carry,
    input  t_lane_ctl i_ctl,
    output t_lane_out o_out
);

    always_comb begin
        logic [5:0] g;
        logic [5:0] eff6;
        logic [5:0] offf6;
        logic [5:0] offc6;
        t_byte      cb;
        o_out = '0;
        eff6  = {1'b0, i_ctl.eff};
        offf6 = {1'b0, i_ctl.off_first};
        offc6 = {1'b0, i_ctl.off_cont};
        for (int j = 0; j < LANE_BYTES; j++) begin
            g  = 6'(LANE * LANE_BYTES + j);
            cb = i_carry[(LANE_BYTES - 1 - j) * 8 +: 8];
            if (g < eff6) begin
                o_out.key[(LANE_BYTES - 1 - j) * 8 +: 8] = byte_sel(i_beat, g + 6'd2);
            end
            if (g < offf6) begin
                o_out.carry_first[(LANE_BYTES - 1 - j) * 8 +: 8] =
                    byte_sel(i_beat, g + 6'd2 + eff6);
            end
            if (g < offc6) begin
                o_out.value[(LANE_BYTES - 1 - j) * 8 +: 8]      = cb;
                // tail of this word that spills into the next one
                o_out.carry_next[(LANE_BYTES - 1 - j) * 8 +: 8] =
                    byte_sel(i_beat, 6'(BEAT_BYTES) - offc6 + g);
            end else begin
                o_out.value[(LANE_BYTES - 1 - j) * 8 +: 8] = byte_sel(i_beat, g - offc6);
            end
        end
    end

endmodule

// ----- rtl/kvp_result_buf.sv -----
// Result buffer: holds the up to three results of one word and hands them out one
// per cycle while the receiver is ready. Depends on kvp_pkg and kvp_result_if.
module kvp_result_buf
    import kvp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_bundle             i_bundle,
    output logic                o_room,
    kvp_result_if.source        o_result
);

    t_result    r_slot [RES_SLOTS];
    logic [1:0] r_cnt;
    logic       pop;

    assign pop    = o_result.valid && o_result.ready;
    assign o_room = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_bundle.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < RES_SLOTS; k++) begin
                r_slot[k] <= i_bundle.slot[k];
            end
        end else if (pop) begin
            for (int k = 0; k < RES_SLOTS - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

    assign o_result.valid      = (r_cnt != 2'd0);
    assign o_result.kind       = r_slot[0].kind;
    assign o_result.word0      = r_slot[0].words[255:192];
    assign o_result.word1      = r_slot[0].words[191:128];
    assign o_result.word2      = r_slot[0].words[127:64];
    assign o_result.word3      = r_slot[0].words[63:0];
    assign o_result.key_length = r_slot[0].key_length;
    assign o_result.count_out  = r_slot[0].count;
    assign o_result.meta_out   = r_slot[0].meta;
    assign o_result.base_out   = r_slot[0].base;
    assign o_result.delta_out  = r_slot[0].delta;
    assign o_result.flags_out  = r_slot[0].flags;
    assign o_result.last       = r_slot[0].last;

endmodule

// ----- rtl/kv_record_beat_parser.sv -----
// Record beat parser top level: record state, four realigning lanes, merge of their
// words into results, and the result buffer. Depends on kvp_pkg, both interfaces,
// kvp_lane and kvp_result_buf.
//
// i_beat carries one 32-byte big-endian word of a stored record per handshake,
// with the descriptor (length, metadata, array flags, slab base, delta) that is
// sampled only on a record's first word. o_result carries the results: a header
// with key and metadata once per record, an optional array request with the
// element count, and realigned zero-padded value words; last marks the final
// result caused by one input word.
// Results of a word are registered in the buffer and appear in the cycle after it
// is accepted. The single result port drains the buffer one result per cycle while
// the receiver is ready, and a new word is taken on the cycle its predecessor's
// last result leaves.
// Reset clears the record state and empties the buffer. When the receiver stalls,
// the head result holds and i_beat.ready drops once the buffer has no room.
module kv_record_beat_parser
    import kvp_pkg::*;
#(
    parameter int KEY_LIMIT = KEY_CAP
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kvp_beat_if.sink     i_beat,
    kvp_result_if.source o_result
);

    logic [15:0] r_bytes_in_flight, n_bytes_in_flight;
    logic [10:0] r_value_left,      n_value_left;
    logic [4:0]  r_carry_offset,    n_carry_offset;
    t_beat       r_carry,           n_carry;
    t_beat       r_held_key,        n_held_key;
    logic [4:0]  r_held_key_size,   n_held_key_size;
    logic [7:0]  r_held_meta,       n_held_meta;
    logic [1:0]  r_held_flags,      n_held_flags;
    logic [63:0] r_held_base,       n_held_base;
    logic [31:0] r_held_delta,      n_held_delta;
    logic        r_count_taken,     n_count_taken;

    t_beat      beat;
    logic       first;
    logic       accept;
    logic       room;
    logic [4:0] hdr_key_len;
    logic [4:0] eff;
    logic [10:0] value_size;
    t_lane_ctl  ctl;
    t_beat      key_v, cbf_v, val_v, cbn_v;
    t_bundle    bundle;

    assign beat        = {i_beat.lane0, i_beat.lane1, i_beat.lane2, i_beat.lane3};
    assign first       = (r_bytes_in_flight == 16'd0);
    assign hdr_key_len = beat[BEAT_W-1 -: 5];
    assign value_size  = beat[BEAT_W-6 -: 11];
    assign eff         = (hdr_key_len < 5'(KEY_LIMIT)) ? hdr_key_len : 5'(KEY_LIMIT);

    assign ctl.eff       = eff;
    assign ctl.off_first = 5'(HDR_SPAN) - eff;
    assign ctl.off_cont  = (r_carry_offset > 5'(HDR_SPAN)) ? 5'(HDR_SPAN) : r_carry_offset;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        t_lane_out lo;
        kvp_lane #(.LANE(l)) u_lane (
            .i_beat  (beat),
            .i_carry (r_carry[BEAT_W-1-64*l -: 64]),
            .i_ctl   (ctl),
            .o_out   (lo)
        );
        assign key_v[BEAT_W-1-64*l -: 64] = lo.key;
        assign cbf_v[BEAT_W-1-64*l -: 64] = lo.carry_first;
        assign val_v[BEAT_W-1-64*l -: 64] = lo.value;
        assign cbn_v[BEAT_W-1-64*l -: 64] = lo.carry_next;
    end

    assign i_beat.ready = room;
    assign accept       = i_beat.valid && i_beat.ready;

    // merge: record state update and candidate results in output order
    always_comb begin
        logic [RES_SLOTS-1:0] p;
        t_kind                c_kind  [RES_SLOTS];
        t_beat                c_words [RES_SLOTS];
        logic [15:0]          c_count [RES_SLOTS];
        logic [1:0]           idx;

        n_bytes_in_flight = r_bytes_in_flight;
        n_value_left      = r_value_left;
        n_carry_offset    = r_carry_offset;
        n_carry           = r_carry;
        n_held_key        = r_held_key;
        n_held_key_size   = r_held_key_size;
        n_held_meta       = r_held_meta;
        n_held_flags      = r_held_flags;
        n_held_base       = r_held_base;
        n_held_delta      = r_held_delta;
        n_count_taken     = r_count_taken;
        p = '0;
        for (int k = 0; k < RES_SLOTS; k++) begin
            c_kind[k]  = KIND_VALUE;
            c_words[k] = '0;
            c_count[k] = '0;
        end

        if (first) begin
            n_held_meta     = i_beat.meta_tag;
            n_held_flags    = {i_beat.array_first_in, i_beat.array_in};
            n_held_base     = i_beat.slab_address;
            n_held_delta    = i_beat.delta_in;
            n_held_key      = key_v;
            n_held_key_size = hdr_key_len;
            n_value_left    = value_size;
            n_carry_offset  = ctl.off_first;
            n_carry         = cbf_v;
            n_count_taken   = 1'b0;
            p[0]       = 1'b1;
            c_kind[0]  = KIND_HEADER;
            c_words[0] = key_v;
            c_count[0] = {5'd0, value_size};
            if (i_beat.array_first_in && ctl.off_first >= 5'd2) begin
                p[1]          = 1'b1;
                c_kind[1]     = KIND_ARRAY;
                c_words[1]    = key_v;
                c_count[1]    = cbf_v[BEAT_W-1 -: 16];
                n_count_taken = 1'b1;
            end
            if (i_beat.record_length > 16'(BEAT_BYTES)) begin
                n_bytes_in_flight = i_beat.record_length - 16'(BEAT_BYTES);
            end else begin
                // whole record in one word: value bytes go out as the tail
                n_bytes_in_flight = '0;
                p[2]           = 1'b1;
                c_kind[2]      = KIND_VALUE;
                c_words[2]     = cbf_v;
                n_carry_offset = '0;
                n_carry        = '0;
            end
        end else if (r_value_left != 11'd0) begin
            if (r_held_flags[1] && !r_count_taken) begin
                p[0]          = 1'b1;
                c_kind[0]     = KIND_ARRAY;
                c_words[0]    = r_held_key;
                c_count[0]    = val_v[BEAT_W-1 -: 16];
                n_count_taken = 1'b1;
            end
            p[1]       = 1'b1;
            c_kind[1]  = KIND_VALUE;
            c_words[1] = val_v;
            n_carry    = cbn_v;
            n_value_left = (r_value_left > 11'(BEAT_BYTES)) ?
                           r_value_left - 11'(BEAT_BYTES) : '0;
            if (r_bytes_in_flight > 16'(BEAT_BYTES)) begin
                n_bytes_in_flight = r_bytes_in_flight - 16'(BEAT_BYTES);
            end else begin
                n_bytes_in_flight = '0;
                if (n_value_left != 11'd0) begin
                    p[2]       = 1'b1;
                    c_kind[2]  = KIND_VALUE;
                    c_words[2] = cbn_v;
                end
                n_carry_offset = '0;
                n_carry        = '0;
            end
        end else begin
            if (r_bytes_in_flight > 16'(BEAT_BYTES)) begin
                n_bytes_in_flight = r_bytes_in_flight - 16'(BEAT_BYTES);
            end else begin
                n_bytes_in_flight = '0;
                n_carry_offset    = '0;
                n_carry           = '0;
            end
        end

        bundle = '0;
        idx    = '0;
        for (int k = 0; k < RES_SLOTS; k++) begin
            if (p[k]) begin
                bundle.slot[idx].kind       = c_kind[k];
                bundle.slot[idx].words      = c_words[k];
                bundle.slot[idx].count      = c_count[k];
                bundle.slot[idx].key_length = n_held_key_size;
                bundle.slot[idx].meta       = n_held_meta;
                bundle.slot[idx].base       = n_held_base;
                bundle.slot[idx].delta      = n_held_delta;
                bundle.slot[idx].flags      = n_held_flags;
                idx = idx + 2'd1;
            end
        end
        if (idx != 2'd0) begin
            bundle.slot[idx - 2'd1].last = 1'b1;
        end
        bundle.cnt = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_flight <= '0;
            r_value_left      <= '0;
            r_carry_offset    <= '0;
            r_carry           <= '0;
            r_held_key        <= '0;
            r_held_key_size   <= '0;
            r_held_meta       <= '0;
            r_held_flags      <= '0;
            r_held_base       <= '0;
            r_held_delta      <= '0;
            r_count_taken     <= 1'b0;
        end else if (accept) begin
            r_bytes_in_flight <= n_bytes_in_flight;
            r_value_left      <= n_value_left;
            r_carry_offset    <= n_carry_offset;
            r_carry           <= n_carry;
            r_held_key        <= n_held_key;
            r_held_key_size   <= n_held_key_size;
            r_held_meta       <= n_held_meta;
            r_held_flags      <= n_held_flags;
            r_held_base       <= n_held_base;
            r_held_delta      <= n_held_delta;
            r_count_taken     <= n_count_taken;
        end
    end

    kvp_result_buf u_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_bundle (bundle),
        .o_room   (room),
        .o_result (o_result)
    );

    // no record open means nothing carried
    a_idle_no_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_in_flight == 16'd0 |-> r_carry_offset == 5'd0)
        else $error("carry offset set with no record open");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_carry_offset <= 5'(HDR_SPAN))
        else $error("carry offset beyond header span");

    a_count_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_taken |-> r_held_flags[1])
        else $error("element count taken for a non-array-first record");

    a_results_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && bundle.cnt != 2'd0 |=> o_result.valid)
        else $error("accepted word lost its results");

endmodule

// ----- tb/sv/kv_record_beat_parser_tb.sv -----
// Testbench for kv_record_beat_parser: sends record words, predicts every result and checks it.
// Depends on kvp_pkg, kvp_beat_if, kvp_result_if and the parser RTL.
module kv_record_beat_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kvp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 170;

    typedef struct packed {
        t_beat       data;
        logic [15:0] record_length;
        logic [7:0]  meta_tag;
        logic        array_first;
        logic        array_member;
        logic [63:0] slab_address;
        logic [31:0] delta;
    } t_beat_item;

    logic i_clk;
    logic i_rst_n;

    kvp_beat_if   beat_if ();
    kvp_result_if res_if ();

    kv_record_beat_parser u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (beat_if),
        .o_result (res_if)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // mirrored record state
    logic [15:0] rec_left    = '0;
    logic [10:0] val_left    = '0;
    int          carry_len   = 0;
    t_beat       carry_word  = '0;
    t_beat       key_word    = '0;
    logic [4:0]  rec_key_len = '0;
    logic [7:0]  rec_meta    = '0;
    logic [1:0]  rec_flags   = '0;
    logic [63:0] rec_base    = '0;
    logic [31:0] rec_delta   = '0;
    logic        count_sent  = 1'b0;

    t_result expected_q[$];
    int      sent_words   = 0;
    int      mismatches   = 0;
    int      src_gap_max  = 0;
    int      sink_gap_max = 0;
    int      sink_wait    = 0;
    int      sink_hold    = 0;
    int      idle_cycles  = 0;

    function automatic t_beat keep_top(t_beat w, int n);
        t_beat mask;
        mask = ~({BEAT_W{1'b1}} >> (8 * n));
        return w & mask;
    endfunction

    function automatic t_result make_result(t_kind kind, t_beat words, logic [15:0] count);
        t_result r;
        r.kind       = kind;
        r.words      = words;
        r.key_length = rec_key_len;
        r.count      = count;
        r.meta       = rec_meta;
        r.base       = rec_base;
        r.delta      = rec_delta;
        r.flags      = rec_flags;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic void predict_results(t_beat_item it);
        t_result fresh[$];
        t_beat   word;
        int      eff;
        int      off;
        if (rec_left == 0) begin
            rec_left    = it.record_length;
            rec_meta    = it.meta_tag;
            rec_flags   = {it.array_first, it.array_member};
            rec_base    = it.slab_address;
            rec_delta   = it.delta;
            rec_key_len = it.data[255:251];
            val_left    = it.data[250:240];
            eff = (rec_key_len < MAX_KEY_BYTES) ? int'(rec_key_len) : MAX_KEY_BYTES;
            if (eff > HDR_SPAN) eff = HDR_SPAN;
            key_word   = keep_top(it.data << 16, eff);
            carry_len  = HDR_SPAN - eff;
            // everything after the key is value, already left-aligned
            carry_word = it.data << (8 * (2 + eff));
            count_sent = 1'b0;
            fresh.push_back(make_result(KIND_HEADER, key_word, 16'(val_left)));
            if (rec_flags[1] && carry_len >= 2) begin
                fresh.push_back(make_result(KIND_ARRAY, key_word, carry_word[255:240]));
                count_sent = 1'b1;
            end
            if (rec_left > BEAT_BYTES) begin
                rec_left = rec_left - 16'(BEAT_BYTES);
            end else begin
                rec_left = '0;
                fresh.push_back(make_result(KIND_VALUE, carry_word, '0));
                carry_len  = 0;
                carry_word = '0;
            end
        end else if (val_left != 0) begin
            off  = (carry_len > HDR_SPAN) ? HDR_SPAN : carry_len;
            word = carry_word | (it.data >> (8 * off));
            if (rec_flags[1] && !count_sent) begin
                fresh.push_back(make_result(KIND_ARRAY, key_word, word[255:240]));
                count_sent = 1'b1;
            end
            fresh.push_back(make_result(KIND_VALUE, word, '0));
            carry_word = it.data << (8 * (BEAT_BYTES - off));
            val_left   = (val_left > BEAT_BYTES) ? 11'(val_left - BEAT_BYTES) : '0;
            if (rec_left > BEAT_BYTES) begin
                rec_left = rec_left - 16'(BEAT_BYTES);
            end else begin
                rec_left = '0;
                // record ran out with value still owed: flush what is carried
                if (val_left != 0) fresh.push_back(make_result(KIND_VALUE, carry_word, '0));
                carry_len  = 0;
                carry_word = '0;
            end
        end else begin
            if (rec_left > BEAT_BYTES) begin
                rec_left = rec_left - 16'(BEAT_BYTES);
            end else begin
                rec_left   = '0;
                carry_len  = 0;
                carry_word = '0;
            end
        end
        if (fresh.size() > 0) begin
            fresh[fresh.size() - 1].last = 1'b1;
        end
        foreach (fresh[i]) expected_q.push_back(fresh[i]);
    endfunction

    function automatic t_beat_item random_beat();
        t_beat_item it;
        for (int i = 0; i < 8; i++) it.data[32 * i +: 32] = $urandom();
        it.record_length = 16'($urandom());
        it.meta_tag      = 8'($urandom());
        it.array_first   = 1'($urandom());
        it.array_member  = 1'($urandom());
        it.slab_address  = {$urandom(), $urandom()};
        it.delta         = $urandom();
        return it;
    endfunction

    task automatic send_beat(input t_beat_item it);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            beat_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        beat_if.valid          <= 1'b1;
        beat_if.lane0          <= it.data[255:192];
        beat_if.lane1          <= it.data[191:128];
        beat_if.lane2          <= it.data[127:64];
        beat_if.lane3          <= it.data[63:0];
        beat_if.record_length  <= it.record_length;
        beat_if.meta_tag       <= it.meta_tag;
        beat_if.array_first_in <= it.array_first;
        beat_if.array_in       <= it.array_member;
        beat_if.slab_address   <= it.slab_address;
        beat_if.delta_in       <= it.delta;
        do @(posedge i_clk); while (beat_if.ready !== 1'b1);
        predict_results(it);
        sent_words++;
    endtask

    // first word carries the header, the rest are random words up to the record length
    task automatic send_record(input logic [4:0] ks, input logic [10:0] vs,
                               input logic [15:0] len, input logic [1:0] flags);
        t_beat_item head;
        int         words;
        head = random_beat();
        head.data[255:240] = {ks, vs};
        head.record_length = len;
        head.array_first   = flags[1];
        head.array_member  = flags[0];
        send_beat(head);
        words = (int'(len) + BEAT_BYTES - 1) / BEAT_BYTES;
        for (int i = 1; i < words; i++) send_beat(random_beat());
    endtask

    task automatic test_field_extremes();
        t_beat_item it;
        src_gap_max  = 13;
        sink_gap_max = 13;
        it = '1;
        it.record_length = '0;
        send_beat(it);
        it = '0;
        send_beat(it);
    endtask

    task automatic test_record_shapes();
        send_record(5'd3, 11'd10, 16'd0, 2'b00);     // zero record length
        send_record(5'd0, 11'd0, 16'd2, 2'b01);      // empty key and value
        send_record(5'd30, 11'd0, 16'd32, 2'b11);    // key fills the word, no room for a count
        send_record(5'd31, 11'd40, 16'd72, 2'b00);   // oversized key
        send_record(5'd4, 11'd20, 16'd26, 2'b11);    // header, count and tail from one word
        send_record(5'd29, 11'd40, 16'd71, 2'b10);   // count straddles carry and next word
        send_record(5'd30, 11'd100, 16'd40, 2'b11);  // late count, record ends with value owed
        send_record(5'd5, 11'd3, 16'd100, 2'b00);    // value done, trailing words yield nothing
        send_record(5'd8, 11'd60, 16'd70, 2'b01);    // array member only
    endtask

    task automatic test_longest_value();
        src_gap_max  = 3;
        sink_gap_max = 3;
        send_record(5'd0, 11'd2047, 16'd2049, 2'b10);
    endtask

    // receiver stalls long while words keep coming, so the buffer fills and input stalls
    task automatic test_output_stall();
        src_gap_max  = 0;
        sink_gap_max = 0;
        sink_hold    = 300;
        for (int i = 0; i < 4; i++) send_record(5'($urandom()), 11'd90, 16'd122, 2'b11);
    endtask

    task automatic test_random_records();
        logic [4:0]  ks;
        logic [10:0] vs;
        logic [15:0] len;
        int          eff;
        int          roll;
        while (sent_words < ITEM_TARGET) begin
            src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 13;
            sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            roll = $urandom_range(0, 9);
            ks   = 5'($urandom());
            vs   = ($urandom_range(0, 24) == 0) ? 11'($urandom_range(161, 320)) :
                                                 11'($urandom_range(0, 160));
            eff  = (ks > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(ks);
            len  = 16'(2 + eff + int'(vs) + $urandom_range(0, 40));
            if (roll == 0) begin
                // arbitrary header against an unrelated length
                vs  = 11'($urandom());
                len = 16'($urandom_range(0, 100));
            end else if (roll == 1) begin
                len = 16'($urandom_range(0, 1 + eff + int'(vs)));
            end
            send_record(ks, vs, len, 2'($urandom()));
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: kind %0d", res_if.kind);
                mismatches++;
            end else begin
                want_res = expected_q.pop_front();
                check_field("kind", 64'(want_res.kind), 64'(res_if.kind));
                check_field("word0", want_res.words[255:192], res_if.word0);
                check_field("word1", want_res.words[191:128], res_if.word1);
                check_field("word2", want_res.words[127:64], res_if.word2);
                check_field("word3", want_res.words[63:0], res_if.word3);
                check_field("key_length", 64'(want_res.key_length), 64'(res_if.key_length));
                check_field("count_out", 64'(want_res.count), 64'(res_if.count_out));
                check_field("meta_out", 64'(want_res.meta), 64'(res_if.meta_out));
                check_field("base_out", want_res.base, res_if.base_out);
                check_field("delta_out", 64'(want_res.delta), 64'(res_if.delta_out));
                check_field("flags_out", 64'(want_res.flags), 64'(res_if.flags_out));
                check_field("last", 64'(want_res.last), 64'(res_if.last));
            end
            sink_wait = $urandom_range(0, sink_gap_max);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (sink_hold > 0) begin
            res_if.ready <= 1'b0;
            sink_hold--;
        end else if (sink_wait > 0) begin
            res_if.ready <= 1'b0;
            sink_wait--;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((beat_if.valid && beat_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("kv_record_beat_parser test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        res_if.ready           = 1'b0;
        beat_if.valid          = 1'b0;
        beat_if.lane0          = '0;
        beat_if.lane1          = '0;
        beat_if.lane2          = '0;
        beat_if.lane3          = '0;
        beat_if.record_length  = '0;
        beat_if.meta_tag       = '0;
        beat_if.array_first_in = 1'b0;
        beat_if.array_in       = 1'b0;
        beat_if.slab_address   = '0;
        beat_if.delta_in       = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_record_shapes();
        test_longest_value();
        test_output_stall();
        test_random_records();

        @(negedge i_clk);
        beat_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("kv_record_beat_parser test passed");
        end else begin
            $display("kv_record_beat_parser test failed");
        end
        $finish;
    end

endmodule
